>>> hw/rtl/indexed_sequence_store_assert.svh
// Assertion macros for the indexed sequence store.
`ifndef INDEXED_SEQUENCE_STORE_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_ASSERT_SVH

`ifndef SYNTHESIS
`define ISST_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ISST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ISST_ASSERT_SAME(lbl, ante, cons, msg)
`define ISST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/isst_pkg.sv
package isst_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int FUNC_W = 3;
    localparam int POS_W  = 5;
    localparam int STAT_W = 2;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam int S_TDATA_W = ((POS_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]  length_now;
    } res_t;

endpackage

>>> hw/rtl/isst_ram.sv
module isst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/isst_ctrl.sv
module isst_ctrl
    import isst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] func,
    input  logic [POS_W-1:0]  position,
    input  logic [DATA_W-1:0] value,
    output res_t              res,
    input  logic              res_take,
    output logic              ram_we,
    output logic [IDX_W-1:0]  ram_waddr,
    output logic [DATA_W-1:0] ram_wdata,
    output logic              ram_re,
    output logic [IDX_W-1:0]  ram_raddr,
    input  logic [DATA_W-1:0] ram_rdata
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SH_RD   = 6'b000010,
        S_SH_WR   = 6'b000100,
        S_RD_WAIT = 6'b001000,
        S_FIN     = 6'b010000,
        S_DONE    = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic              up_reg, up_next;
    logic              ins_reg, ins_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0] rd_reg, rd_next;

    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  cnt_ext_m1;
    logic [CNT_W-1:0]  cnt_dec;
    logic [IDX_W-1:0]  cnt_m1;
    logic [IDX_W-1:0]  idx_step;

    // One incrementer/decrementer walks the index in either direction.
    assign idx_step   = up_reg ? IDX_W'(idx_reg - 1'b1) : IDX_W'(idx_reg + 1'b1);
    assign pos_ext    = CMP_W'(position);
    assign cnt_ext    = CMP_W'(count_reg);
    assign cnt_ext_m1 = CMP_W'(cnt_ext - 1'b1);
    assign cnt_dec    = count_reg - 1'b1;
    assign cnt_m1     = IDX_W'(cnt_dec);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        up_next     = up_reg;
        ins_next    = ins_reg;
        status_next = status_reg;
        rd_next     = rd_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = idx_step;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    status_next = STAT_OK;
                    rd_next     = '0;
                    pos_next    = IDX_W'(position);
                    val_next    = value;
                    state_next  = S_DONE;
                    unique case (func)
                        FUNC_INSERT:
                        begin
                            if (pos_ext > cnt_ext)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                ins_next   = 1'b1;
                                up_next    = 1'b1;
                                idx_next   = IDX_W'(count_reg);
                                state_next = (pos_ext == cnt_ext) ? S_FIN : S_SH_RD;
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                ins_next   = 1'b0;
                                up_next    = 1'b0;
                                idx_next   = IDX_W'(position);
                                state_next = (pos_ext == cnt_ext_m1) ? S_FIN : S_SH_RD;
                            end
                        end
                        FUNC_READ:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = IDX_W'(position);
                                state_next = S_RD_WAIT;
                            end
                        end
                        FUNC_WRITE:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = IDX_W'(position);
                                ram_wdata = value;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_SH_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_step;
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                idx_next  = idx_step;
                if (up_reg ? (idx_step == pos_reg) : (idx_step == cnt_m1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SH_RD;
                end
            end
            S_RD_WAIT:
            begin
                rd_next    = ram_rdata;
                state_next = S_DONE;
            end
            S_FIN:
            begin
                if (ins_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg;
                    ram_wdata  = val_reg;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    count_next = cnt_dec;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        up_reg     <= up_next;
        ins_reg    <= ins_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign res.valid      = (state_reg == S_DONE);
    assign res.status     = status_reg;
    assign res.read_value = rd_reg;
    assign res.length_now = count_reg;

endmodule

>>> hw/rtl/indexed_sequence_store.sv
// Indexed sequence store: a bounded ordered list of words addressed by position.
// A request enters on the s_axis channel: tuser carries the operation (insert,
// remove, read, write, clear) and tdata the position and the data word.
// Each request returns one item on the m_axis channel: tuser carries the status
// and tdata the word read and the list length after the request.
// The list lives in a small RAM with a registered read port. Insert and remove
// move the entries behind the addressed position one at a time, a read and a
// write for each, through a single index stepper.
// Clear, write, rejected and unused requests go straight to the result, a read
// waits for the RAM data, and an insert or remove shifts, then sets the length.
// The next request can be accepted in the cycle after the result is handed to
// the output register.
// Reset empties the list; the stored words are not cleared and need no
// clearing pass. The output register holds the result while m_axis_tready is
// low, and a finished result waits in the sequencer until the register frees.
module indexed_sequence_store
    import isst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // position, value, zero fill
    input  logic [FUNC_W-1:0]    s_axis_tuser,  // func
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // read_value, length_now, zero fill
    output logic [STAT_W-1:0]    m_axis_tuser   // status
);

    `include "indexed_sequence_store_assert.svh"

    res_t              res;
    logic              res_take;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [CNT_W-1:0]  out_len_reg;

    isst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .func      (s_axis_tuser),
        .position  (s_axis_tdata[POS_W-1:0]),
        .value     (s_axis_tdata[POS_W+DATA_W-1:POS_W]),
        .res       (res),
        .res_take  (res_take),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    isst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_take = res.valid && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_status_reg <= res.status;
            out_data_reg   <= res.read_value;
            out_len_reg    <= res.length_now;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = M_TDATA_W'({out_len_reg, out_data_reg});

    `ISST_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "request accepted while the previous one is still in progress")
    `ISST_ASSERT_SAME(a_len_bound, m_axis_tvalid,
        out_len_reg <= CNT_W'(DEPTH), "reported length exceeds the list depth")
    `ISST_ASSERT_SAME(a_err_zero, m_axis_tvalid && (m_axis_tuser != STAT_OK),
        out_data_reg == '0, "rejected request returned a nonzero word")
    `ISST_ASSERT_SAME(a_take_ready, res_take && res.valid, !s_axis_tready,
        "result handed over while the sequencer reports idle")

endmodule
